/* rtl/fdpe_pkg.sv */
// ----------------------------------------------------------------------------
// fdpe_pkg
// shared types and constants of the fractional divider parameter encoder
// ----------------------------------------------------------------------------
package fdpe_pkg;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOT_INIT = 2'd1;
    localparam logic [1:0] ST_INVALID  = 2'd2;

    // integer part limits
    localparam logic [9:0] A_PLL_MIN = 10'd15;
    localparam logic [9:0] A_PLL_MAX = 10'd90;
    localparam logic [9:0] A_MS_MIN  = 10'd4;
    localparam logic [9:0] A_MS_MAX  = 10'd900;
    localparam logic [2:0] OUT_COUNT = 3'd3;

    // field widths
    localparam int FRAC_W = 20;
    localparam int P1_W   = 18;

    // long division of 128*b by c: 28 dividend bits, four per cycle
    localparam int DVD_W      = 28;
    localparam int DIV_RADIX  = 4;
    localparam int DIV_ITERS  = DVD_W / DIV_RADIX;
    localparam int DIV_CNT_W  = 3;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_ITERS - 1);

    localparam logic [P1_W-1:0] P1_OFFSET = 18'd512;

    // classified request
    typedef struct packed {
        logic [1:0]        status;
        logic              ms;
        logic [9:0]        a;
        logic [FRAC_W-1:0] b;
        logic [FRAC_W-1:0] c;
        logic [2:0]        rdiv;
        logic              b_zero;
        logic              c_one;
    } t_cmd;

    // request with its quotient and remainder
    typedef struct packed {
        t_cmd              cmd;
        logic [P1_W-1:0]   quo;
        logic [FRAC_W-1:0] rem;
    } t_res;

endpackage

/* rtl/fdpe_front.sv */
// ----------------------------------------------------------------------------
// fdpe_front
// request checks and classification, two-entry command queue
// ----------------------------------------------------------------------------
module fdpe_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_init,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic            i_req_type,
    input  logic [9:0]      i_int_part,
    input  logic [20:0]     i_numerator,
    input  logic [20:0]     i_denominator,
    input  logic [2:0]      i_output_index,
    input  logic [2:0]      i_rdiv_code,
    output logic            o_q_valid,
    input  logic            i_q_pop,
    output fdpe_pkg::t_cmd  o_q_cmd
);
    import fdpe_pkg::*;

    t_cmd       w_cmd;
    logic       w_a_ok;
    logic       w_bad;
    logic       w_push;
    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;

    always_comb begin
        if (i_req_type) begin
            w_a_ok = (i_int_part >= A_MS_MIN) && (i_int_part <= A_MS_MAX);
        end else begin
            w_a_ok = (i_int_part >= A_PLL_MIN) && (i_int_part <= A_PLL_MAX);
        end
        w_bad = !w_a_ok || (i_denominator == 21'd0) || i_numerator[20]
              || i_denominator[20] || (i_req_type && (i_output_index >= OUT_COUNT));

        w_cmd.status = !i_init ? ST_NOT_INIT : (w_bad ? ST_INVALID : ST_OK);
        w_cmd.ms     = i_req_type;
        w_cmd.a      = i_int_part;
        w_cmd.b      = i_numerator[FRAC_W-1:0];
        w_cmd.c      = i_denominator[FRAC_W-1:0];
        w_cmd.rdiv   = i_rdiv_code;
        w_cmd.b_zero = (i_numerator == 21'd0);
        w_cmd.c_one  = (i_denominator == 21'd1);
    end

    assign o_stall   = (r_cnt == 2'd2);
    assign w_push    = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_cmd   = r_q[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (w_push && !i_q_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!w_push && i_q_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (i_q_pop) begin
                r_rp <= !r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

endmodule

/* rtl/fdpe_div.sv */
// ----------------------------------------------------------------------------
// fdpe_div
// iterative restoring divider for floor(128b/c), four quotient bits a cycle
// ----------------------------------------------------------------------------
module fdpe_div (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    output logic            o_q_pop,
    input  fdpe_pkg::t_cmd  i_q_cmd,
    output logic            o_res_valid,
    input  logic            i_res_take,
    output fdpe_pkg::t_res  o_res
);
    import fdpe_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]           r_state;
    logic [1:0]           n_state;
    logic [DIV_CNT_W-1:0] r_cnt;
    t_cmd                 r_cmd;
    logic [FRAC_W-1:0]    r_rem;
    logic [DVD_W-1:0]     r_dvd;
    logic [P1_W-1:0]      r_quo;
    logic [FRAC_W-1:0]    n_rem;
    logic [DIV_RADIX-1:0] n_qbits;

    // four restoring steps per cycle
    always_comb begin
        logic [FRAC_W:0] s;
        n_rem = r_rem;
        for (int i = 0; i < DIV_RADIX; i++) begin
            s = {n_rem, r_dvd[DVD_W-1-i]};
            if (s >= {1'b0, r_cmd.c}) begin
                s                       = s - {1'b0, r_cmd.c};
                n_qbits[DIV_RADIX-1-i]  = 1'b1;
            end else begin
                n_qbits[DIV_RADIX-1-i]  = 1'b0;
            end
            n_rem = s[FRAC_W-1:0];
        end
    end

    assign o_q_pop = i_q_valid
                  && ((r_state == S_IDLE) || ((r_state == S_DONE) && i_res_take));
    assign o_res_valid = (r_state == S_DONE);
    assign o_res.cmd   = r_cmd;
    assign o_res.quo   = r_quo;
    assign o_res.rem   = r_rem;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (r_cnt == DIV_LAST) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = i_q_valid ? S_RUN : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (o_q_pop) begin
                r_cnt <= '0;
            end else if (r_state == S_RUN) begin
                r_cnt <= r_cnt + DIV_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= i_q_cmd;
            r_rem <= '0;
            r_dvd <= DVD_W'({i_q_cmd.b, 7'b0});
            r_quo <= '0;
        end else if (r_state == S_RUN) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[DVD_W-DIV_RADIX-1:0], {DIV_RADIX{1'b0}}};
            r_quo <= {r_quo[P1_W-DIV_RADIX-1:0], n_qbits};
        end
    end

endmodule

/* rtl/fdpe_emit.sv */
// ----------------------------------------------------------------------------
// fdpe_emit
// parameter assembly and byte sequencer with registered output
// ----------------------------------------------------------------------------
module fdpe_emit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_res_valid,
    output logic            o_res_take,
    input  fdpe_pkg::t_res  i_res,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [2:0]      o_byte_index,
    output logic [7:0]      o_data,
    output logic [1:0]      o_status,
    output logic            o_last
);
    import fdpe_pkg::*;

    // hold stage
    logic              r_h_valid;
    logic [2:0]        r_h_k;
    logic [1:0]        r_h_status;
    logic              r_h_ms;
    logic [2:0]        r_h_rdiv;
    logic [P1_W-1:0]   r_h_p1;
    logic [FRAC_W-1:0] r_h_p2;
    logic [FRAC_W-1:0] r_h_p3;

    // output stage
    logic              r_o_valid;
    logic [2:0]        r_o_idx;
    logic [7:0]        r_o_data;
    logic [1:0]        r_o_status;
    logic              r_o_last;

    logic              w_mv;
    logic              w_h_last;
    logic [7:0]        w_byte;
    logic [P1_W-1:0]   w_p1;
    logic [FRAC_W-1:0] w_p2;
    logic [FRAC_W-1:0] w_p3;

    assign w_mv       = r_h_valid && (!r_o_valid || !i_stall);
    assign w_h_last   = (r_h_status != ST_OK) || (r_h_k == 3'd7);
    assign o_res_take = i_res_valid && (!r_h_valid || (w_mv && w_h_last));

    // p1 = 128a + q - 512, with the special cases folded in by the quotient
    always_comb begin
        w_p1 = P1_W'({i_res.cmd.a, 7'b0}) + i_res.quo - P1_OFFSET;
        if (i_res.cmd.b_zero) begin
            w_p2 = '0;
            w_p3 = FRAC_W'(1);
        end else if (i_res.cmd.c_one) begin
            w_p2 = FRAC_W'({i_res.cmd.b, 7'b0}) - FRAC_W'(128);
            w_p3 = FRAC_W'(1);
        end else begin
            w_p2 = i_res.rem;
            w_p3 = i_res.cmd.c;
        end
    end

    always_comb begin
        case (r_h_k)
            3'd0:    w_byte = r_h_p3[15:8];
            3'd1:    w_byte = r_h_p3[7:0];
            3'd2:    w_byte = {1'b0, (r_h_ms ? r_h_rdiv : 3'b000), 2'b00, r_h_p1[17:16]};
            3'd3:    w_byte = r_h_p1[15:8];
            3'd4:    w_byte = r_h_p1[7:0];
            3'd5:    w_byte = {r_h_p3[19:16], r_h_p2[19:16]};
            3'd6:    w_byte = r_h_p2[15:8];
            3'd7:    w_byte = r_h_p2[7:0];
            default: w_byte = 8'd0;
        endcase
        if (r_h_status != ST_OK) begin
            w_byte = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_valid <= 1'b0;
            r_h_k     <= 3'd0;
            r_o_valid <= 1'b0;
        end else begin
            if (o_res_take) begin
                r_h_valid <= 1'b1;
                r_h_k     <= 3'd0;
            end else if (w_mv) begin
                r_h_valid <= !w_h_last;
                r_h_k     <= r_h_k + 3'd1;
            end
            if (w_mv) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_res_take) begin
            r_h_status <= i_res.cmd.status;
            r_h_ms     <= i_res.cmd.ms;
            r_h_rdiv   <= i_res.cmd.rdiv;
            r_h_p1     <= w_p1;
            r_h_p2     <= w_p2;
            r_h_p3     <= w_p3;
        end
        if (w_mv) begin
            r_o_idx    <= r_h_k;
            r_o_data   <= w_byte;
            r_o_status <= r_h_status;
            r_o_last   <= w_h_last;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_byte_index = r_o_idx;
    assign o_data       = r_o_data;
    assign o_status     = r_o_status;
    assign o_last       = r_o_last;

endmodule

/* rtl/fractional_divider_param_encoder.sv */
// ----------------------------------------------------------------------------
// fractional_divider_param_encoder
// encodes a fractional divide ratio a + b/c into eight packed register bytes
// ----------------------------------------------------------------------------
// A request (PLL feedback or output multisynth divider, given as a, b, c) is
// checked and turned into P1 = 128a + floor(128b/c) - 512, P2 = the remainder
// of 128b/c and P3 = c (P2 = 0 and P3 = 1 when b = 0, P2 = 128b - 128 and
// P3 = 1 when c = 1), then sent out as eight words, byte_index 0 to 7, with
// last on byte 7. A request that fails its checks gives a single word with
// data 0 and a nonzero status (1 when i_cfg_wdata has not set initialized,
// 2 for a bad parameter). The front checks and queues requests (two deep);
// an iterative divider resolves four quotient bits a cycle and then holds
// the finished request while the byte sequencer sends the one before it,
// so the divider works on the next request while words of the last go out.
// ----------------------------------------------------------------------------
module fractional_divider_param_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    // request channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_req_type,
    input  logic [9:0]  i_int_part,
    input  logic [20:0] i_numerator,
    input  logic [20:0] i_denominator,
    input  logic [2:0]  i_output_index,
    input  logic [2:0]  i_rdiv_code,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_byte_index,
    output logic [7:0]  o_data,
    output logic [1:0]  o_status,
    output logic        o_last
);
    import fdpe_pkg::*;

    // initialized flag
    logic r_init;

    // front to divider queue
    logic w_q_valid;
    logic w_q_pop;
    t_cmd w_q_cmd;

    // divider to sequencer handoff
    logic w_res_valid;
    logic w_res_take;
    t_res w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init <= 1'b0;
        end else if (i_cfg_we) begin
            r_init <= i_cfg_wdata;
        end
    end

    // checks, status and special-case flags, then the command queue
    fdpe_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_init         (r_init),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_req_type     (i_req_type),
        .i_int_part     (i_int_part),
        .i_numerator    (i_numerator),
        .i_denominator  (i_denominator),
        .i_output_index (i_output_index),
        .i_rdiv_code    (i_rdiv_code),
        .o_q_valid      (w_q_valid),
        .i_q_pop        (w_q_pop),
        .o_q_cmd        (w_q_cmd)
    );

    // floor(128b/c) and remainder
    fdpe_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .o_q_pop     (w_q_pop),
        .i_q_cmd     (w_q_cmd),
        .o_res_valid (w_res_valid),
        .i_res_take  (w_res_take),
        .o_res       (w_res)
    );

    // p1/p2/p3 assembly and one word per cycle out unless i_stall holds the output
    fdpe_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_res_valid  (w_res_valid),
        .o_res_take   (w_res_take),
        .i_res        (w_res),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_byte_index (o_byte_index),
        .o_data       (o_data),
        .o_status     (o_status),
        .o_last       (o_last)
    );

endmodule

/* verif/fractional_divider_param_encoder_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fractional_divider_param_encoder_tb
// self-checking bench for the fractional divider parameter encoder
// ----------------------------------------------------------------------------
// Requests go in through the valid/stall request channel. Each accepted
// request is run through a local model of the P1/P2/P3 encoding, and the
// eight packed bytes, or the single error word, are queued. Every word taken
// from the result channel is checked against the oldest queued one. Directed
// tests cover the range limits, both divider kinds, the zero-numerator and
// unit-denominator cases and the error paths. Random traffic then runs under
// three idling mixes, plus a long result-side hold-off that backs the block
// up into its request channel.
// ----------------------------------------------------------------------------
module fractional_divider_param_encoder_tb;
    import fdpe_pkg::*;

    // request kinds
    localparam bit REQ_PLL = 1'b0;
    localparam bit REQ_MS  = 1'b1;

    localparam logic [20:0] FRAC_MAX     = 21'h0FFFFF;
    localparam int          DRAIN_CYCLES = 40;       // block latency plus margin
    localparam int          HOLD_CYCLES  = 250;      // long result-side hold-off
    localparam int          TIMEOUT_NS   = 2_000_000;

    // one result word as seen on the output ports
    typedef struct packed {
        logic [2:0] idx;
        logic [7:0] data;
        logic [1:0] status;
        logic       last;
    } reg_byte_t;

    // clock, reset and block inputs, all known from time zero
    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_cfg_we       = 1'b0;
    logic        i_cfg_wdata    = 1'b0;
    logic        i_valid        = 1'b0;
    logic        i_req_type     = 1'b0;
    logic [9:0]  i_int_part     = '0;
    logic [20:0] i_numerator    = '0;
    logic [20:0] i_denominator  = '0;
    logic [2:0]  i_output_index = '0;
    logic [2:0]  i_rdiv_code    = '0;
    logic        i_stall        = 1'b0;

    logic        o_stall;
    logic        o_valid;
    logic [2:0]  o_byte_index;
    logic [7:0]  o_data;
    logic [1:0]  o_status;
    logic        o_last;

    // bench state
    reg_byte_t   expected_bytes[$];
    bit          cfg_initialized = 1'b0;   // local copy of the register
    int unsigned tx_idle_pct     = 0;
    int unsigned rx_stall_pct    = 0;
    int unsigned mismatches      = 0;

    // hold-off request: the test flips hold_tgl, the receiver counts it out
    bit          hold_tgl  = 1'b0;
    bit          hold_seen = 1'b0;
    int unsigned hold_left = 0;

    fractional_divider_param_encoder i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_req_type     (i_req_type),
        .i_int_part     (i_int_part),
        .i_numerator    (i_numerator),
        .i_denominator  (i_denominator),
        .i_output_index (i_output_index),
        .i_rdiv_code    (i_rdiv_code),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_byte_index   (o_byte_index),
        .o_data         (o_data),
        .o_status       (o_status),
        .o_last         (o_last)
    );

    // 4 ns clock
    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // encoding model: queues the words one request should produce
    // ------------------------------------------------------------------------
    function automatic void encode_divider(input bit ms, input logic [9:0] a,
                                           input logic [20:0] b, input logic [20:0] c,
                                           input logic [2:0] outn, input logic [2:0] rdiv);
        logic [31:0] p1, p2, p3, quo;
        logic [31:0] a32, b32, c32;
        logic [7:0]  pkt [8];
        bit          bad;

        // not-initialized wins over every parameter check
        if (!cfg_initialized) begin
            expected_bytes.push_back('{3'd0, 8'd0, ST_NOT_INIT, 1'b1});
            return;
        end

        if (ms) begin
            bad = (a < A_MS_MIN) || (a > A_MS_MAX);
        end else begin
            bad = (a < A_PLL_MIN) || (a > A_PLL_MAX);
        end
        if (c == 0 || b > FRAC_MAX || c > FRAC_MAX) bad = 1'b1;
        if (ms && outn >= OUT_COUNT) bad = 1'b1;
        if (bad) begin
            expected_bytes.push_back('{3'd0, 8'd0, ST_INVALID, 1'b1});
            return;
        end

        a32 = 32'(a);
        b32 = 32'(b);
        c32 = 32'(c);
        if (b == 0) begin
            // zero numerator: pure integer ratio
            p1 = 32'd128 * a32 - 32'd512;
            p2 = 32'd0;
            p3 = 32'd1;
        end else if (c == 1) begin
            // unit denominator keeps its odd P2 = 128b - 128 form
            p1 = 32'd128 * a32 + 32'd128 * b32 - 32'd512;
            p2 = 32'd128 * b32 - 32'd128;
            p3 = 32'd1;
        end else begin
            quo = (32'd128 * b32) / c32;
            p1  = 32'd128 * a32 + quo - 32'd512;
            p2  = 32'd128 * b32 - c32 * quo;
            p3  = c32;
        end

        pkt[0] = p3[15:8];
        pkt[1] = p3[7:0];
        pkt[2] = {1'b0, (ms ? rdiv : 3'd0), 2'b00, p1[17:16]};
        pkt[3] = p1[15:8];
        pkt[4] = p1[7:0];
        pkt[5] = {p3[19:16], p2[19:16]};
        pkt[6] = p2[15:8];
        pkt[7] = p2[7:0];
        for (int k = 0; k < 8; k++) begin
            expected_bytes.push_back('{3'(k), pkt[k], ST_OK, (k == 7)});
        end
    endfunction

    // ------------------------------------------------------------------------
    // result side: random stall, or a counted hold-off when one is requested
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_tgl != hold_seen) begin
            hold_seen <= hold_tgl;
            hold_left <= HOLD_CYCLES;
            i_stall   <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < rx_stall_pct);
        end
    end

    // checker: every word taken from the block is compared with the oldest
    // queued expectation
    always @(posedge i_clk) begin
        reg_byte_t got;
        reg_byte_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_byte_index, o_data, o_status, o_last};
            if (expected_bytes.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected word idx=%0d data=%02h status=%0d last=%0b",
                         $time, got.idx, got.data, got.status, got.last);
            end else begin
                want = expected_bytes.pop_front();
                if (got != want) begin
                    mismatches++;
                    $display("%0t: mismatch expected idx=%0d data=%02h status=%0d last=%0b",
                             $time, want.idx, want.data, want.status, want.last);
                    $display("%0t:          actual   idx=%0d data=%02h status=%0d last=%0b",
                             $time, got.idx, got.data, got.status, got.last);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // shared tasks
    // ------------------------------------------------------------------------

    // offer one request word, with random idle cycles ahead of it; valid stays
    // high afterwards so back-to-back words need no second assignment per step
    task automatic send_request(input bit ms, input logic [9:0] a, input logic [20:0] b,
                                input logic [20:0] c, input logic [2:0] outn,
                                input logic [2:0] rdiv);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_req_type     <= ms;
        i_int_part     <= a;
        i_numerator    <= b;
        i_denominator  <= c;
        i_output_index <= outn;
        i_rdiv_code    <= rdiv;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        encode_divider(ms, a, b, c, outn, rdiv);
    endtask

    // stop offering, wait for every queued word, then let the pipe settle
    task automatic drain;
        i_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // register write, only ever issued with the block drained
    task automatic write_initialized(input bit value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we        <= 1'b0;
        cfg_initialized  = value;
    endtask

    // one random request: mostly legal ratios, the rest broken or pure noise
    task automatic send_random_request;
        bit          ms;
        logic [9:0]  a;
        logic [20:0] b, c;
        logic [2:0]  outn, rdiv;
        int unsigned pick;

        ms   = 1'($urandom_range(0, 1));
        a    = 10'(ms ? $urandom_range(4, 900) : $urandom_range(15, 90));
        rdiv = 3'($urandom_range(0, 7));
        outn = 3'($urandom_range(0, 2));
        // spread operand sizes so every quotient width shows up
        case ($urandom_range(0, 7))
            0:       c = 21'd1;
            1:       c = FRAC_MAX;
            default: c = 21'($urandom_range(1, 32'hFFFFF) >> $urandom_range(0, 19));
        endcase
        if (c == 0) c = 21'd1;
        case ($urandom_range(0, 7))
            0:       b = 21'd0;
            1:       b = FRAC_MAX;
            default: b = 21'($urandom_range(1, 32'hFFFFF) >> $urandom_range(0, 19));
        endcase

        pick = $urandom_range(0, 99);
        if (pick >= 90) begin
            // raw noise over the full field widths
            ms   = 1'($urandom_range(0, 1));
            a    = 10'($urandom_range(0, 1023));
            b    = 21'($urandom);
            c    = 21'($urandom);
            outn = 3'($urandom_range(0, 7));
        end else if (pick >= 78) begin
            // legal request with one field pushed out of range
            case ($urandom_range(0, 4))
                0: begin
                    if (ms) a = 10'($urandom_range(0, 1) ? $urandom_range(0, 3)
                                                         : $urandom_range(901, 1023));
                    else    a = 10'($urandom_range(0, 1) ? $urandom_range(0, 14)
                                                         : $urandom_range(91, 1023));
                end
                1: c = 21'd0;
                2: b = 21'($urandom_range(32'h100000, 32'h1FFFFF));
                3: c = 21'($urandom_range(32'h100000, 32'h1FFFFF));
                default: begin
                    ms   = REQ_MS;
                    outn = 3'($urandom_range(3, 7));
                end
            endcase
        end else if (!ms) begin
            // output index is a don't-care on a PLL request
            outn = 3'($urandom_range(0, 7));
        end
        send_request(ms, a, b, c, outn, rdiv);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // every request must fail with not-initialized while the bit is clear
    task automatic test_not_initialized;
        write_initialized(1'b0);
        send_request(REQ_PLL, 10'd50, 21'd3, 21'd7, 3'd0, 3'd0);
        send_request(REQ_MS, 10'd1023, 21'h1FFFFF, 21'd0, 3'd7, 3'd7);
        send_request(REQ_MS, 10'd4, 21'd1, 21'd1, 3'd2, 3'd5);
        drain();
    endtask

    // range limits, special ratios and each parameter error
    task automatic test_directed_limits;
        write_initialized(1'b1);
        // PLL integer limits and ignored multisynth fields
        send_request(REQ_PLL, 10'd15, 21'd0, 21'd1, 3'd0, 3'd0);
        send_request(REQ_PLL, 10'd90, FRAC_MAX, FRAC_MAX, 3'd0, 3'd0);
        send_request(REQ_PLL, 10'd14, 21'd1, 21'd2, 3'd0, 3'd0);
        send_request(REQ_PLL, 10'd91, 21'd1, 21'd2, 3'd0, 3'd0);
        send_request(REQ_PLL, 10'd50, 21'd3, 21'd7, 3'd7, 3'd7);
        // multisynth integer limits
        send_request(REQ_MS, 10'd4, 21'd1, 21'd1, 3'd0, 3'd0);
        send_request(REQ_MS, 10'd900, FRAC_MAX, 21'd1, 3'd1, 3'd7);
        send_request(REQ_MS, 10'd3, 21'd1, 21'd2, 3'd0, 3'd0);
        send_request(REQ_MS, 10'd901, 21'd1, 21'd2, 3'd0, 3'd0);
        send_request(REQ_MS, 10'd0, 21'd1, 21'd2, 3'd0, 3'd0);
        send_request(REQ_MS, 10'd1023, 21'd1, 21'd2, 3'd0, 3'd0);
        // output index limit
        send_request(REQ_MS, 10'd100, 21'd5, 21'd9, 3'd2, 3'd7);
        send_request(REQ_MS, 10'd100, 21'd5, 21'd9, 3'd3, 3'd1);
        send_request(REQ_MS, 10'd100, 21'd5, 21'd9, 3'd7, 3'd1);
        // denominator and numerator field limits
        send_request(REQ_MS, 10'd100, 21'd5, 21'd0, 3'd0, 3'd0);
        send_request(REQ_MS, 10'd100, 21'h100000, 21'd9, 3'd0, 3'd0);
        send_request(REQ_MS, 10'd100, 21'd5, 21'h100000, 3'd0, 3'd0);
        send_request(REQ_PLL, 10'd40, 21'h1FFFFF, 21'h1FFFFF, 3'd0, 3'd0);
        // zero numerator with a real denominator still gives P3 = 1
        send_request(REQ_MS, 10'd6, 21'd0, 21'd12345, 3'd0, 3'd2);
        // numerator above denominator, and the largest quotient
        send_request(REQ_PLL, 10'd36, 21'd12345, 21'd12344, 3'd0, 3'd0);
        send_request(REQ_MS, 10'd900, FRAC_MAX, 21'd2, 3'd2, 3'd4);
        drain();
    endtask

    // random traffic under one idling mix
    task automatic test_random_traffic(input int count, input int tx_pct, input int rx_pct);
        tx_idle_pct   = tx_pct;
        rx_stall_pct <= rx_pct;
        repeat (count) send_random_request();
        drain();
    endtask

    // long result hold-off while requests keep coming: the block must fill up
    // and push back on its request side without losing a word
    task automatic test_backpressure;
        tx_idle_pct   = 0;
        rx_stall_pct <= 0;
        hold_tgl     <= ~hold_tgl;
        repeat (14) send_random_request();
        drain();
    endtask

    // clearing the register mid-run turns every request back into an error
    task automatic test_config_toggle;
        tx_idle_pct   = 20;
        rx_stall_pct <= 20;
        write_initialized(1'b0);
        repeat (10) send_random_request();
        drain();
        write_initialized(1'b1);
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_not_initialized();
        test_directed_limits();
        test_random_traffic(110, 30, 77);
        test_backpressure();
        test_random_traffic(110, 77, 30);
        test_config_toggle();
        test_random_traffic(110, 0, 0);

        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("%0t: timeout with %0d words outstanding", $time, expected_bytes.size());
        $display("tb: failure");
        $finish;
    end

endmodule
